// ----- hw/rtl/spk_pkg.sv -----
`default_nettype none

package spk_pkg;

    localparam int WORD_W = 32;
    localparam int ROUNDS = 27;
    localparam int RIDX_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int KEY_WORDS = 4;
    localparam int KIDX_W = 2;

    localparam int ROT_X = 8;
    localparam int ROT_Y = 3;

    localparam logic [KIDX_W-1:0] KEY_IDX_0 = 2'd0;
    localparam logic [KIDX_W-1:0] KEY_IDX_1 = 2'd1;
    localparam logic [KIDX_W-1:0] KEY_IDX_2 = 2'd2;
    localparam logic [KIDX_W-1:0] KEY_IDX_3 = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    // Block halves plus the round key and the three schedule words.
    // sched_0 is the word the next round updates.
    typedef struct packed {
        word_t x;
        word_t y;
        word_t rk;
        word_t sched_0;
        word_t sched_1;
        word_t sched_2;
    } spk_state_t;

    typedef struct packed {
        word_t x;
        word_t y;
    } spk_pair_t;

    function automatic spk_pair_t spk_round(input word_t x, input word_t y, input word_t k);
        word_t nx;
        spk_pair_t res;
        nx = ({x[ROT_X-1:0], x[WORD_W-1:ROT_X]} + y) ^ k;
        res.x = nx;
        res.y = {y[WORD_W-ROT_Y-1:0], y[WORD_W-1:WORD_W-ROT_Y]} ^ nx;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/spk_cell.sv -----
`default_nettype none

module spk_cell import spk_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spk_state_t        in_state,
    input  wire logic [RIDX_W-1:0] round_idx,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spk_state_t             out_state
);

    logic       vld_reg;
    spk_state_t st_reg;
    spk_state_t st_next;
    spk_pair_t  data_rnd;
    spk_pair_t  key_rnd;

    // Take a new beat when empty or when the downstream cell drains this one.
    assign in_ready = !vld_reg || out_ready;

    always_comb begin
        data_rnd = spk_round(in_state.x, in_state.y, in_state.rk);
        key_rnd  = spk_round(in_state.sched_0, in_state.rk, WORD_W'(round_idx));
        st_next.x       = data_rnd.x;
        st_next.y       = data_rnd.y;
        st_next.rk      = key_rnd.y;
        // Rotate the schedule words so the next cell updates the following slot.
        st_next.sched_0 = in_state.sched_1;
        st_next.sched_1 = in_state.sched_2;
        st_next.sched_2 = key_rnd.x;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_state = st_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/speck64_128_block_encrypt_unit.sv -----
// SPECK 64/128 block encryption, one fully unrolled round per pipeline cell.
//
// Input channel (s_valid/s_ready): one beat carries a plaintext block,
// s_plain_low as the y word and s_plain_high as the x word.
// Result channel (m_valid/m_ready): one beat per block, m_cipher_low (y) and
// m_cipher_high (x), in the order the blocks were accepted.
// Key port (cfg_valid/cfg_ready): cfg_index selects key word 0..3, cfg_data is
// the word. cfg_ready is always high. Write keys only while no block is in
// flight; each cell derives its round key from the key that entered with it.
//
// Each block passes through the 27 round cells in order, one registered cell per round.
// Throughput: one block per cycle while m_ready is high, set by the 27-cell round chain.
// When m_ready is low the last cell holds its block; earlier cells keep moving
// until they run into occupied cells, so bubbles close up and s_ready drops
// only when every cell holds a block.
// Reset (aresetn low, synchronous) empties all cells and clears the key to zero.
`default_nettype none

module speck64_128_block_encrypt_unit import spk_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [WORD_W-1:0] s_plain_low,
    input  wire logic [WORD_W-1:0] s_plain_high,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [WORD_W-1:0] m_cipher_low,
    output logic      [WORD_W-1:0] m_cipher_high,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [KIDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0] cfg_data
);

    word_t      key_reg [KEY_WORDS];
    spk_state_t chain_state [ROUNDS+1];
    logic       chain_valid [ROUNDS+1];
    logic       chain_ready [ROUNDS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                KEY_IDX_0: key_reg[0] <= cfg_data;
                KEY_IDX_1: key_reg[1] <= cfg_data;
                KEY_IDX_2: key_reg[2] <= cfg_data;
                KEY_IDX_3: key_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign chain_state[0] = '{x: s_plain_high, y: s_plain_low, rk: key_reg[0],
                              sched_0: key_reg[1], sched_1: key_reg[2],
                              sched_2: key_reg[3]};

    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        spk_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_state  (chain_state[g]),
            .round_idx (RIDX_W'(g)),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_state (chain_state[g+1])
        );
    end

    assign chain_ready[ROUNDS] = m_ready;
    assign m_valid             = chain_valid[ROUNDS];
    assign m_cipher_low        = chain_state[ROUNDS].y;
    assign m_cipher_high       = chain_state[ROUNDS].x;

endmodule

`default_nettype wire

// ----- hw/rtl/spk_checker.sv -----
`default_nettype none

module spk_checker import spk_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [WORD_W-1:0] m_cipher_low,
    input wire logic [WORD_W-1:0] m_cipher_high
);

    // A stalled result beat stays up.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_cipher_low) && $stable(m_cipher_high))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the output cell empty, every cell can advance, so input is open.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output cell");

    // An accepted beat with no stall can never block the next one.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind speck64_128_block_encrypt_unit spk_checker u_spk_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_cipher_low  (m_cipher_low),
    .m_cipher_high (m_cipher_high)
);

`default_nettype wire
